// ===== sv/jpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick port with autofire: shared package
// Item kinds, event codes, register indexes, axis codes and the structs that
// travel between the top level and the state unit.
// ----------------------------------------------------------------------------
package jpa_pkg;

  // Field widths of the channels.
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned EventWidth = 3;
  localparam int unsigned PortWidth  = 8;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 17;
  localparam int unsigned BurstWidth   = 17;
  localparam int unsigned HalfWidth    = 8;

  // Default sizes of the shot and frame counters.
  localparam int unsigned ShotCountWidthDef  = 16;
  localparam int unsigned FrameCountWidthDef = 8;

  // Register reset values.
  localparam logic [BurstWidth-1:0] BurstReset = 17'h1FFFF;
  localparam logic [HalfWidth-1:0]  HalfReset  = 8'd10;

  // Kind of an input item. The unused code behaves as a port read.
  typedef enum logic [KindWidth-1:0] {
    KIND_EVENT  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  // Joystick event codes.
  typedef enum logic [EventWidth-1:0] {
    EV_UP        = 3'd0,
    EV_DOWN      = 3'd1,
    EV_LEFT      = 3'd2,
    EV_RIGHT     = 3'd3,
    EV_FIRE      = 3'd4,
    EV_REL_X     = 3'd5,
    EV_REL_Y     = 3'd6,
    EV_REL_XY    = 3'd7
  } event_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_AUTOFIRE = 2'd0,
    CFG_SHOTS    = 2'd1,
    CFG_HALF     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_e;

  // Axis positions.
  typedef enum logic [1:0] {
    AXIS_CENTER = 2'd0,
    AXIS_PLUS   = 2'd1,
    AXIS_SPARE  = 2'd2,
    AXIS_MINUS  = 2'd3
  } axis_e;

  // Autofire settings as stored by the configuration port.
  typedef struct packed {
    logic                  autofire_enable;
    logic [BurstWidth-1:0] shots_per_burst;
    logic [HalfWidth-1:0]  half_period_frames;
  } cfg_t;

  // Joystick position and button as seen on the port.
  typedef struct packed {
    axis_e axis_x;
    axis_e axis_y;
    logic  fire_down;
  } joy_t;

  // Active-low port byte from the joystick state and the mouse bits.
  function automatic logic [PortWidth-1:0] port_value(joy_t joy,
                                                      logic [PortWidth-1:0] mouse);
    logic [PortWidth-1:0] r;
    r = '1;
    if (joy.axis_y == AXIS_MINUS) r[0] = 1'b0;
    if (joy.axis_y == AXIS_PLUS)  r[1] = 1'b0;
    if (joy.axis_x == AXIS_MINUS) r[2] = 1'b0;
    if (joy.axis_x == AXIS_PLUS)  r[3] = 1'b0;
    if (joy.fire_down)            r[4] = 1'b0;
    return r & mouse;
  endfunction

endpackage

// ===== sv/jpa_if.sv =====
// ----------------------------------------------------------------------------
// Joystick port with autofire: channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------

// Input items: event, frame tick or port read.
interface jpa_in_if import jpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KindWidth-1:0]  kind;
  logic [EventWidth-1:0] event_code;
  logic                  fire_off;
  logic [PortWidth-1:0]  mouse_bits;

  modport source (output valid, kind, event_code, fire_off, mouse_bits,
                  input ready);
  modport sink   (input valid, kind, event_code, fire_off, mouse_bits,
                  output ready);
endinterface

// Result items: the active-low port byte.
interface jpa_out_if import jpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PortWidth-1:0] port_bits;

  modport source (output valid, port_bits, input ready);
  modport sink   (input valid, port_bits, output ready);
endinterface

// Register writes.
interface jpa_cfg_if import jpa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/jpa_state.sv =====
// ----------------------------------------------------------------------------
// Joystick port with autofire: state unit
// Holds axes, button, shot count and frame counter, and updates them for
// each accepted item.
// ----------------------------------------------------------------------------
module jpa_state import jpa_pkg::*; #(
  parameter int unsigned SHOT_COUNT_WIDTH  = ShotCountWidthDef,
  parameter int unsigned FRAME_COUNT_WIDTH = FrameCountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  kind_e                 kind_i,
  input  logic [EventWidth-1:0] event_code_i,
  input  logic                  fire_off_i,
  input  cfg_t                  cfg_i,
  output joy_t                  joy_next_o
);

  localparam logic [32:0] ShotMaxWide = (33'd1 << SHOT_COUNT_WIDTH) - 33'd1;
  localparam logic [31:0] ShotMax     = ShotMaxWide[31:0];

  joy_t                         joy_q, joy_d;
  logic [SHOT_COUNT_WIDTH-1:0]  shots_q, shots_d;
  logic                         unlim_q, unlim_d;
  logic [FRAME_COUNT_WIDTH-1:0] frames_q, frames_d;

  logic [FRAME_COUNT_WIDTH-1:0] half_masked;
  logic [FRAME_COUNT_WIDTH-1:0] frames_dec;
  logic [31:0]                  burst_ext;
  logic [SHOT_COUNT_WIDTH-1:0]  burst_sat;
  logic                         burst_active;

  // Half period cut or widened to the frame counter, burst size saturated.
  always_comb begin
    logic [HalfWidth+FRAME_COUNT_WIDTH-1:0] half_ext;
    half_ext    = {{FRAME_COUNT_WIDTH{1'b0}}, cfg_i.half_period_frames};
    half_masked = half_ext[FRAME_COUNT_WIDTH-1:0];
    burst_ext   = {16'd0, cfg_i.shots_per_burst[15:0]};
    burst_sat   = (burst_ext > ShotMax) ? ShotMax[SHOT_COUNT_WIDTH-1:0]
                                        : burst_ext[SHOT_COUNT_WIDTH-1:0];
    frames_dec  = frames_q - {{(FRAME_COUNT_WIDTH-1){1'b0}}, 1'b1};
  end

  assign burst_active = unlim_q || (shots_q != '0);

  // Next state for the accepted item.
  always_comb begin
    joy_d    = joy_q;
    shots_d  = shots_q;
    unlim_d  = unlim_q;
    frames_d = frames_q;
    case (kind_i)
      KIND_EVENT: begin
        if (fire_off_i) begin
          if (!cfg_i.autofire_enable) joy_d.fire_down = 1'b0;
        end else begin
          case (event_e'(event_code_i))
            EV_UP:     joy_d.axis_y = AXIS_MINUS;
            EV_DOWN:   joy_d.axis_y = AXIS_PLUS;
            EV_LEFT:   joy_d.axis_x = AXIS_MINUS;
            EV_RIGHT:  joy_d.axis_x = AXIS_PLUS;
            EV_FIRE: begin
              if (!cfg_i.autofire_enable) begin
                joy_d.fire_down = 1'b1;
              end else if (burst_active) begin
                // A press during a burst stops it at once.
                shots_d         = '0;
                unlim_d         = 1'b0;
                joy_d.fire_down = 1'b0;
              end else begin
                // Load a new burst; the top bit marks an unlimited one.
                if (cfg_i.shots_per_burst[BurstWidth-1]) begin
                  unlim_d = 1'b1;
                  shots_d = '0;
                end else begin
                  unlim_d = 1'b0;
                  shots_d = burst_sat;
                end
                joy_d.fire_down = 1'b1;
                frames_d        = half_masked;
              end
            end
            EV_REL_X:  joy_d.axis_x = AXIS_CENTER;
            EV_REL_Y:  joy_d.axis_y = AXIS_CENTER;
            EV_REL_XY: begin
              joy_d.axis_x = AXIS_CENTER;
              joy_d.axis_y = AXIS_CENTER;
            end
            default: begin
              joy_d.axis_x = AXIS_CENTER;
              joy_d.axis_y = AXIS_CENTER;
            end
          endcase
        end
      end
      KIND_TICK: begin
        // Count down; on reaching zero toggle the button if a burst runs.
        if (frames_q != '0) begin
          frames_d = frames_dec;
          if ((frames_dec == '0) && cfg_i.autofire_enable &&
              (cfg_i.half_period_frames != '0) && burst_active) begin
            if (joy_q.fire_down) begin
              joy_d.fire_down = 1'b0;
              if (!unlim_q) shots_d = shots_q - {{(SHOT_COUNT_WIDTH-1){1'b0}}, 1'b1};
            end else begin
              joy_d.fire_down = 1'b1;
            end
            frames_d = half_masked;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, updated only on accepted items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joy_q    <= '{axis_x: AXIS_CENTER, axis_y: AXIS_CENTER, fire_down: 1'b0};
      shots_q  <= '0;
      unlim_q  <= 1'b0;
      frames_q <= '0;
    end else if (step_i) begin
      joy_q    <= joy_d;
      shots_q  <= shots_d;
      unlim_q  <= unlim_d;
      frames_q <= frames_d;
    end
  end

  assign joy_next_o = joy_d;

endmodule

// ===== sv/joystick_port_autofire.sv =====
// ----------------------------------------------------------------------------
// Joystick port with autofire: top level
// Emulated control port. Every item (event, frame tick, port read) returns
// the active-low port byte after that item's update.
// ----------------------------------------------------------------------------
// The result of an accepted item is loaded into the output register.
// Throughput: one item per cycle while results are taken; the state unit updates in the accepting cycle.
// The input side stays ready while the output register is empty or being taken.
// Reset clears axes, button, burst and frame counter; autofire is off,
// bursts are unlimited and the half period is ten frames.
module joystick_port_autofire import jpa_pkg::*; #(
  parameter int unsigned SHOT_COUNT_WIDTH  = ShotCountWidthDef,
  parameter int unsigned FRAME_COUNT_WIDTH = FrameCountWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jpa_in_if.sink     in_chan,
  jpa_out_if.source  out_chan,
  jpa_cfg_if.sink    cfg_chan
);

  cfg_t                 cfg_q;
  logic                 out_valid_q;
  logic [PortWidth-1:0] port_q;
  logic                 step;
  joy_t                 joy_next;

  // Register writes are always taken.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{autofire_enable: 1'b0, shots_per_burst: BurstReset,
                 half_period_frames: HalfReset};
    end else if (cfg_chan.valid) begin
      case (cfg_idx_e'(cfg_chan.index))
        CFG_AUTOFIRE: cfg_q.autofire_enable    <= cfg_chan.data[0];
        CFG_SHOTS:    cfg_q.shots_per_burst    <= cfg_chan.data[BurstWidth-1:0];
        CFG_HALF:     cfg_q.half_period_frames <= cfg_chan.data[HalfWidth-1:0];
        default: ;
      endcase
    end
  end

  // An item is taken whenever the output register is free or draining.
  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign step          = in_chan.valid && in_chan.ready;

  jpa_state #(
    .SHOT_COUNT_WIDTH  (SHOT_COUNT_WIDTH),
    .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .kind_i       (kind_e'(in_chan.kind)),
    .event_code_i (in_chan.event_code),
    .fire_off_i   (in_chan.fire_off),
    .cfg_i        (cfg_q),
    .joy_next_o   (joy_next)
  );

  // Output register holding one result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      port_q <= port_value(joy_next, in_chan.mouse_bits);
    end
  end

  assign out_chan.valid     = out_valid_q;
  assign out_chan.port_bits = port_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the joystick port with autofire
// A directed table walks the axes, the fire button and the autofire bursts
// (limited, unlimited, empty, pulsing off). Random phases with fresh register
// settings follow. Each result byte is checked against its row's literal, if any,
// else a cycle-free port model, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import jpa_pkg::*;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned RandomPhases  = 9;
  localparam int unsigned PhaseItems    = 50;
  localparam int unsigned DrainLimit    = 2000;

  // One row of the directed table: a register write or an input item.
  typedef struct packed {
    logic                    is_write;
    cfg_idx_e                reg_idx;
    logic [CfgDataWidth-1:0] reg_data;
    kind_e                   kind;
    event_e                  ev;
    logic                    rel;
    logic [PortWidth-1:0]    mouse;
    logic                    lit_ok;
    logic [PortWidth-1:0]    lit;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jpa_in_if  in_chan ();
  jpa_out_if out_chan ();
  jpa_cfg_if cfg_chan ();

  joystick_port_autofire i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #6 clk_i = ~clk_i;

  // Model of the port: joystick state, burst state and register copies.
  axis_e                joy_x, joy_y;
  logic                 btn_down;
  logic [15:0]          shots_left_m;
  logic                 endless;
  logic [7:0]           frames_left;
  logic                 cf_autofire;
  logic [BurstWidth-1:0] cf_burst;
  logic [HalfWidth-1:0] cf_half;

  // Port bytes still owed by the block, oldest first.
  logic [PortWidth-1:0] port_due[$];

  // Literal expectation that travels with the item on the input channel.
  logic                 lit_use;
  logic [PortWidth-1:0] lit_val;

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned src_mode;
  int unsigned n_events, n_ticks, n_reads, n_presses, n_toggles, n_writes, n_phases;
  row_t        script[$];

  // Applies one item to the model and returns the port byte it answers with.
  function automatic logic [PortWidth-1:0] advance_port(kind_e k, event_e e, logic rel,
                                                        logic [PortWidth-1:0] mouse);
    logic [PortWidth-1:0] r;
    if (k == KIND_EVENT) begin
      n_events++;
      if (rel) begin
        // A fire release only counts while autofire is off.
        if (!cf_autofire) btn_down = 1'b0;
      end else begin
        case (e)
          EV_UP:     joy_y = AXIS_MINUS;
          EV_DOWN:   joy_y = AXIS_PLUS;
          EV_LEFT:   joy_x = AXIS_MINUS;
          EV_RIGHT:  joy_x = AXIS_PLUS;
          EV_REL_X:  joy_x = AXIS_CENTER;
          EV_REL_Y:  joy_y = AXIS_CENTER;
          EV_REL_XY: begin
            joy_x = AXIS_CENTER;
            joy_y = AXIS_CENTER;
          end
          default: begin
            n_presses++;
            if (!cf_autofire) begin
              btn_down = 1'b1;
            end else if (endless || shots_left_m != 0) begin
              // A press during a burst ends it at once.
              shots_left_m = '0;
              endless      = 1'b0;
              btn_down     = 1'b0;
            end else begin
              // Loaded counts fit the 16-bit shot counter, so no clipping here.
              if (cf_burst[16]) begin
                endless      = 1'b1;
                shots_left_m = '0;
              end else begin
                endless      = 1'b0;
                shots_left_m = cf_burst[15:0];
              end
              btn_down    = 1'b1;
              frames_left = cf_half;
            end
          end
        endcase
      end
    end else if (k == KIND_TICK) begin
      n_ticks++;
      if (frames_left != 0) begin
        frames_left--;
        if (frames_left == 0 && cf_autofire && cf_half != 0 &&
            (endless || shots_left_m != 0)) begin
          n_toggles++;
          if (btn_down) begin
            btn_down = 1'b0;
            if (!endless) shots_left_m--;
          end else begin
            btn_down = 1'b1;
          end
          frames_left = cf_half;
        end
      end
    end else begin
      n_reads++;
    end
    r = '1;
    if (joy_y == AXIS_MINUS) r[0] = 1'b0;
    if (joy_y == AXIS_PLUS)  r[1] = 1'b0;
    if (joy_x == AXIS_MINUS) r[2] = 1'b0;
    if (joy_x == AXIS_PLUS)  r[3] = 1'b0;
    if (btn_down)            r[4] = 1'b0;
    return r & mouse;
  endfunction

  // Counts a failure and reports the first few.
  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("ERROR at cycle %0d: %s", cycles, msg);
  endfunction

  // Observes all three channels at each rising edge and checks result items.
  always @(posedge clk_i) begin
    logic [PortWidth-1:0] want;
    cycles++;
    if (rst_ni === 1'b1) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        n_writes++;
        case (cfg_idx_e'(cfg_chan.index))
          CFG_AUTOFIRE: cf_autofire = cfg_chan.data[0];
          CFG_SHOTS:    cf_burst    = cfg_chan.data;
          CFG_HALF:     cf_half     = cfg_chan.data[HalfWidth-1:0];
          default:      ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        want = advance_port(kind_e'(in_chan.kind), event_e'(in_chan.event_code),
                            in_chan.fire_off, in_chan.mouse_bits);
        if (lit_use) want = lit_val;
        port_due.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (port_due.size() == 0) begin
          note_failure($sformatf("unexpected port byte %02h", out_chan.port_bits));
        end else begin
          want = port_due.pop_front();
          if (out_chan.port_bits !== want)
            note_failure($sformatf("port byte expected %02h, got %02h", want,
                                   out_chan.port_bits));
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Idle cycles before one item: none, a random gap, or a random gap only now and then.
  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 10);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    endcase
  endfunction

  // Result side: stalls before each item, in modes that change every 40 items.
  initial begin
    int unsigned stall;
    int unsigned mode;
    int unsigned taken;
    out_chan.ready <= 1'b0;
    mode  = 1;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(mode);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
      taken++;
      if (taken % 40 == 0) mode = $urandom_range(0, 2);
    end
  end

  // Drives one item and returns at the edge that accepts it.
  task automatic send_item(kind_e k, event_e e, logic rel, logic [PortWidth-1:0] mouse,
                           logic lit_ok, logic [PortWidth-1:0] lit);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= k;
    in_chan.event_code <= e;
    in_chan.fire_off   <= rel;
    in_chan.mouse_bits <= mouse;
    lit_use            <= lit_ok;
    lit_val            <= lit;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  // Stops sending and waits until every owed port byte has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (port_due.size() != 0);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic row_t item_row(kind_e k, event_e e, logic rel,
                                    logic [PortWidth-1:0] mouse, logic lit_ok,
                                    logic [PortWidth-1:0] lit);
    row_t r;
    r          = '0;
    r.reg_idx  = CFG_NONE;
    r.kind     = k;
    r.ev       = e;
    r.rel      = rel;
    r.mouse    = mouse;
    r.lit_ok   = lit_ok;
    r.lit      = lit;
    return r;
  endfunction

  function automatic row_t write_row(cfg_idx_e idx, logic [CfgDataWidth-1:0] value);
    row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = value;
    r.kind     = KIND_READ;
    r.ev       = EV_UP;
    return r;
  endfunction

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int unsigned pick;
    int unsigned left;
    kind_e       k;
    event_e      e;
    logic        rel;
    logic [PortWidth-1:0]    mouse;
    logic [BurstWidth-1:0]   burst;
    logic [HalfWidth-1:0]    half;

    // Model after reset.
    joy_x        = AXIS_CENTER;
    joy_y        = AXIS_CENTER;
    btn_down     = 1'b0;
    shots_left_m = '0;
    endless      = 1'b0;
    frames_left  = '0;
    cf_autofire  = 1'b0;
    cf_burst     = BurstReset;
    cf_half      = HalfReset;
    mismatches   = 0;
    cycles       = 0;
    src_mode     = 1;

    rst_ni             <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_READ;
    in_chan.event_code <= EV_UP;
    in_chan.fire_off   <= 1'b0;
    in_chan.mouse_bits <= '1;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= CFG_NONE;
    cfg_chan.data      <= '0;
    lit_use            <= 1'b0;
    lit_val            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, mouse masking and the spare kind.
    script.push_back(item_row(KIND_READ,  EV_UP,     1'b0, 8'hFF, 1'b1, 8'hFF));
    script.push_back(item_row(KIND_READ,  EV_UP,     1'b0, 8'h00, 1'b1, 8'h00));
    script.push_back(item_row(KIND_SPARE, EV_REL_XY, 1'b1, 8'hFF, 1'b1, 8'hFF));
    // Every direction, then the axis releases.
    script.push_back(item_row(KIND_EVENT, EV_UP,     1'b0, 8'hFF, 1'b1, 8'hFE));
    script.push_back(item_row(KIND_EVENT, EV_DOWN,   1'b0, 8'hFF, 1'b1, 8'hFD));
    script.push_back(item_row(KIND_EVENT, EV_LEFT,   1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_RIGHT,  1'b0, 8'h5A, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_REL_XY, 1'b0, 8'hFF, 1'b1, 8'hFF));
    // Plain fire with autofire off; a tick with an idle counter changes nothing.
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_TICK,  EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b1, 8'hFF, 1'b1, 8'hFF));
    script.push_back(item_row(KIND_EVENT, EV_UP,     1'b0, 8'hA5, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_LEFT,   1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_REL_Y,  1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_REL_X,  1'b0, 8'hFF, 1'b1, 8'hFF));
    // Two-shot burst pulsing every frame, with a release ignored under autofire.
    script.push_back(write_row(CFG_AUTOFIRE, 17'd1));
    script.push_back(write_row(CFG_SHOTS,    17'd2));
    script.push_back(write_row(CFG_HALF,     17'd1));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_TICK,  EV_UP,     1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_TICK,  EV_UP,     1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_TICK,  EV_UP,     1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_TICK,  EV_UP,     1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b1, 8'hFF, 1'b0, 8'h00));
    // Zero shots: each press holds the button and starts no burst.
    script.push_back(write_row(CFG_SHOTS,    17'd0));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    // Unlimited burst with pulsing off, stopped by a second press.
    script.push_back(write_row(CFG_SHOTS,    17'h1FFFF));
    script.push_back(write_row(CFG_HALF,     17'd0));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_TICK,  EV_UP,     1'b0, 8'hFF, 1'b0, 8'h00));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hFF));
    // Largest shot count and half period; the spare index must be ignored.
    script.push_back(write_row(CFG_SHOTS,    17'd65535));
    script.push_back(write_row(CFG_HALF,     17'd255));
    script.push_back(write_row(CFG_NONE,     17'h1ABCD));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hEF));
    script.push_back(item_row(KIND_EVENT, EV_FIRE,   1'b0, 8'hFF, 1'b1, 8'hFF));

    foreach (script[i]) begin
      if (script[i].is_write) begin
        write_reg(script[i].reg_idx, script[i].reg_data);
      end else begin
        send_item(script[i].kind, script[i].ev, script[i].rel, script[i].mouse,
                  script[i].lit_ok, script[i].lit);
      end
    end

    // Random phases, each with its own settings and idle pattern.
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      n_phases++;
      pick = $urandom_range(0, 5);
      case (pick)
        0:       burst = 17'h1FFFF;
        1:       burst = 17'd0;
        2:       burst = 17'd65535;
        3:       burst = 17'($urandom);
        default: burst = 17'($urandom_range(1, 6));
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
        0:       half = 8'd0;
        1:       half = 8'd255;
        default: half = 8'($urandom_range(1, 4));
      endcase
      // Upper data bits are junk for the narrow registers.
      write_reg(CFG_AUTOFIRE, {16'($urandom), ($urandom_range(0, 9) < 7)});
      write_reg(CFG_SHOTS, burst);
      write_reg(CFG_HALF, {9'($urandom), half});
      src_mode = $urandom_range(0, 2);

      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // Once, mid-run, let the block run dry before sending on.
        if (ph == RandomPhases / 2 && n == PhaseItems / 2) wait_drained();
        pick = $urandom_range(0, 99);
        e    = event_e'($urandom_range(0, 7));
        rel  = ($urandom_range(0, 6) == 0);
        if (pick < 30) begin
          k    = KIND_EVENT;
          left = $urandom_range(0, 99);
          if (left < 35) begin
            e   = EV_FIRE;
            rel = 1'b0;
          end else if (left < 50) begin
            rel = 1'b1;
          end else begin
            rel = 1'b0;
          end
        end else if (pick < 80) begin
          k = KIND_TICK;
        end else if (pick < 95) begin
          k = KIND_READ;
        end else begin
          k = KIND_SPARE;
        end
        mouse = ($urandom_range(0, 9) < 6) ? 8'hFF : 8'($urandom);
        send_item(k, e, rel, mouse, 1'b0, 8'h00);
      end
    end

    // Wait for the last bytes, bounded, then a few quiet cycles.
    in_chan.valid <= 1'b0;
    left = DrainLimit;
    while (port_due.size() != 0 && left > 0) begin
      @(posedge clk_i);
      left--;
    end
    repeat (4) @(posedge clk_i);
    if (port_due.size() != 0)
      note_failure($sformatf("%0d port bytes never arrived", port_due.size()));

    $display("Covered %0d events (%0d fire presses), %0d ticks, %0d reads; %0d button toggles.",
             n_events, n_presses, n_ticks, n_reads, n_toggles);
    $display("%0d register writes over %0d random setting phases, %0d failures.",
             n_writes, n_phases, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
